FILE: rtl/core/s235fc_pkg.sv
`timescale 1ns / 1ps
// Package for the five-smooth factor check.
// Holds the value width, exponent widths and the modular inverse constants.
// No dependencies.
package s235fc_pkg;

	localparam int VALUE_BITS = 32;
	localparam int EXP2_W = 5;
	localparam int EXP3_W = 5;
	localparam int EXP5_W = 4;

	// Trailing-zero search halves the window each step: 16, 8, 4, 2, 1.
	localparam int TZ_STEPS  = $clog2(VALUE_BITS);
	localparam int TZ_STEP_W = $clog2(TZ_STEPS);
	localparam int TZ_SHIFT_W = $clog2(VALUE_BITS);

	// Inverses of 3 and 5 modulo 2^32, and the largest exact quotients.
	// An odd x is divisible by p exactly when x * inv(p) mod 2^32 <= (2^32-1)/p,
	// and the product is then the quotient itself.
	localparam logic [VALUE_BITS-1:0] INV_THREE   = 32'hAAAA_AAAB;
	localparam logic [VALUE_BITS-1:0] INV_FIVE    = 32'hCCCC_CCCD;
	localparam logic [VALUE_BITS-1:0] LIMIT_THREE = 32'h5555_5555;
	localparam logic [VALUE_BITS-1:0] LIMIT_FIVE  = 32'h3333_3333;

	localparam int MAX_EXP_THREE = 20;
	localparam int MAX_EXP_FIVE  = 13;

	// Mask of the low 2^step bits, used by the trailing-zero search.
	function automatic logic [VALUE_BITS-1:0] tz_mask(input logic [TZ_STEP_W-1:0] step);
		logic [VALUE_BITS-1:0] m;
		m = '0;
		for (int i = 0; i < VALUE_BITS; i++) begin
			m[i] = (i < (1 << step));
		end
		return m;
	endfunction

endpackage

FILE: rtl/core/smooth_235_factor_check.sv
`timescale 1ns / 1ps
// Five-smooth factor check: decides whether a value equals 2^a * 3^b * 5^c.
// Depends on s235fc_pkg for widths, inverse constants and the search mask.

// One item is taken at a time; in_stall stays high from acceptance until the
// result has been written to the output register, which can still be waiting
// for the consumer while the next item is accepted. An item is accepted, then
// passes through the binary trailing-zero search, a state to start the threes,
// the division by three once per factor of three plus a final check, a state
// to start the fives, the division by five once per factor of five plus a final
// check, and a state to write the result; a zero value goes straight to the
// write state, and the search stops early once the cofactor is one. The single
// shared 32 by 32 multiplier forms the exact quotient by a modular inverse, one
// factor per cycle. For a value that is not smooth the exponents found before
// the search stopped are reported, and a stage that did not run reports zero.
module smooth_235_factor_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [s235fc_pkg::VALUE_BITS-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                is_smooth,
	output logic [s235fc_pkg::EXP2_W-1:0]       exp_two,
	output logic [s235fc_pkg::EXP3_W-1:0]       exp_three,
	output logic [s235fc_pkg::EXP5_W-1:0]       exp_five
);
	import s235fc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b000_0001,
		S_TZ     = 7'b000_0010,
		S_START3 = 7'b000_0100,
		S_DIV3   = 7'b000_1000,
		S_START5 = 7'b001_0000,
		S_DIV5   = 7'b010_0000,
		S_DONE   = 7'b100_0000
	} state_t;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   x_q;
	logic [VALUE_BITS-1:0]   prod_q;
	logic [TZ_STEP_W-1:0]    tz_step_q;
	logic [EXP2_W-1:0]       e2_q;
	logic [EXP3_W-1:0]       e3_q;
	logic [EXP5_W-1:0]       e5_q;

	logic                    out_valid_q;
	logic                    is_smooth_q;
	logic [EXP2_W-1:0]       exp_two_q;
	logic [EXP3_W-1:0]       exp_three_q;
	logic [EXP5_W-1:0]       exp_five_q;

	logic                    in_take;
	logic                    out_free;
	logic [VALUE_BITS-1:0]   mul_a;
	logic [VALUE_BITS-1:0]   mul_b;
	logic [VALUE_BITS-1:0]   mul_lo;
	logic [TZ_SHIFT_W-1:0]   tz_shift;
	logic                    tz_zero;
	logic                    x_above_one;
	logic                    div3_ok;
	logic                    div5_ok;

	// Handshake on both sides.
	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign is_smooth = is_smooth_q;
	assign exp_two   = exp_two_q;
	assign exp_three = exp_three_q;
	assign exp_five  = exp_five_q;

	// Shared multiplier: starts from the cofactor, then keeps dividing the quotient.
	// Only the low half of the product is needed for the modular inverse.
	always_comb begin
		mul_a = ((state_q == S_START3) || (state_q == S_START5)) ? x_q : prod_q;
		mul_b = ((state_q == S_START3) || (state_q == S_DIV3)) ? INV_THREE : INV_FIVE;
		mul_lo = mul_a * mul_b;
	end

	// Trailing-zero window test and the loop conditions.
	always_comb begin
		tz_shift    = TZ_SHIFT_W'(1) << tz_step_q;
		tz_zero     = ((x_q & tz_mask(tz_step_q)) == '0);
		x_above_one = (x_q > VALUE_BITS'(1));
		div3_ok     = x_above_one && (prod_q <= LIMIT_THREE);
		div5_ok     = x_above_one && (prod_q <= LIMIT_FIVE);
	end

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tz_step_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q   <= (value == '0) ? S_DONE : S_TZ;
						tz_step_q <= TZ_STEP_W'(TZ_STEPS - 1);
					end
				end
				S_TZ: begin
					if (tz_step_q == '0) begin
						state_q <= S_START3;
					end else begin
						tz_step_q <= tz_step_q - TZ_STEP_W'(1);
					end
				end
				S_START3: begin
					state_q <= x_above_one ? S_DIV3 : S_DONE;
				end
				S_DIV3: begin
					if (!div3_ok) begin
						state_q <= x_above_one ? S_START5 : S_DONE;
					end
				end
				S_START5: begin
					state_q <= S_DIV5;
				end
				S_DIV5: begin
					if (!div5_ok) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Cofactor, product and exponent counters.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					x_q  <= value;
					e2_q <= '0;
					e3_q <= '0;
					e5_q <= '0;
				end
			end
			S_TZ: begin
				if (tz_zero) begin
					x_q  <= x_q >> tz_shift;
					e2_q <= e2_q + EXP2_W'(tz_shift);
				end
			end
			S_START3, S_START5: begin
				prod_q <= mul_lo;
			end
			S_DIV3: begin
				if (div3_ok) begin
					x_q    <= prod_q;
					prod_q <= mul_lo;
					e3_q   <= e3_q + EXP3_W'(1);
				end
			end
			S_DIV5: begin
				if (div5_ok) begin
					x_q    <= prod_q;
					prod_q <= mul_lo;
					e5_q   <= e5_q + EXP5_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: filled once the previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			is_smooth_q <= (x_q == VALUE_BITS'(1));
			exp_two_q   <= e2_q;
			exp_three_q <= e3_q;
			exp_five_q  <= e5_q;
		end
	end

`ifndef SYNTHESIS
	// An accepted item always leaves the idle state on the next edge.
	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == S_TZ) || (state_q == S_DONE))
		else $error("accepted item did not start the search");

	// A result is only written when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(exp_two_q) &&
			$stable(exp_three_q))
		else $error("waiting result was overwritten");

	// Exponents of three and five never exceed what a 32-bit value allows.
	a_exp_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (exp_three_q <= EXP3_W'(MAX_EXP_THREE)) &&
			(exp_five_q <= EXP5_W'(MAX_EXP_FIVE)))
		else $error("exponent beyond its range");

	// A zero value is reported as not smooth and with no factors.
	a_trivial_smooth: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && out_free && (x_q == '0)) |=>
			!is_smooth_q && (exp_two_q == '0) && (exp_three_q == '0) && (exp_five_q == '0))
		else $error("zero reported with factors or as smooth");
`endif

endmodule
